// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger, outside reset.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ebcm_pkg.sv -----
// Shared constants, register codes and types of the banded ERP cost matrix core.
package ebcm_pkg;

    localparam int MAX_LENGTH_DEF = 1024;
    localparam int COST_WIDTH_DEF = 48;

    localparam int LEN_W      = 11;
    localparam int SAMPLE_W   = 32;
    localparam int DIST_W     = 32;
    localparam int OUT_COST_W = 48;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Register indexes (byte address is four times the index)
    localparam logic [REG_IDX_W-1:0] REG_LENGTH_X   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH_Y   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BAND_WIDTH = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAP_VALUE  = 2'd3;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic [LEN_W-1:0]           length_x;
        logic [LEN_W-1:0]           length_y;
        logic [LEN_W-1:0]           band_width;
        logic signed [SAMPLE_W-1:0] gap_value;
    } t_cfg;

    // Per-cell position flags, worked out when the cell is accepted
    typedef struct packed {
        logic first_row;   // cell lies in row one
        logic first_col;   // cell lies in column one
        logic col_edge;    // column-zero sum is finite for this row
        logic diag_edge;   // column-zero sum of the row above is finite
        logic row_edge;    // row-zero sum is finite for this column
        logic in_band;     // cell lies inside the band
        logic last;        // final cell of the matrix
    } t_cell_flags;

endpackage

// ----- hw/rtl/ebcm_cfg_regs.sv -----
// APB register file holding lengths, band width and gap value.
module ebcm_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ebcm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ebcm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ebcm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output ebcm_pkg::t_cfg                     o_cfg
);

    localparam int LW = ebcm_pkg::LEN_W;
    localparam int DW = ebcm_pkg::APB_DATA_W;

    logic [LW-1:0]                     r_length_x;
    logic [LW-1:0]                     r_length_y;
    logic [LW-1:0]                     r_band_width;
    logic [ebcm_pkg::SAMPLE_W-1:0]     r_gap_value;
    logic [ebcm_pkg::REG_IDX_W-1:0]    w_idx;
    logic                              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ebcm_pkg::APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_x   <= LW'(1);
            r_length_y   <= LW'(1);
            r_band_width <= '0;
            r_gap_value  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                ebcm_pkg::REG_LENGTH_X:   r_length_x   <= pwdata[LW-1:0];
                ebcm_pkg::REG_LENGTH_Y:   r_length_y   <= pwdata[LW-1:0];
                ebcm_pkg::REG_BAND_WIDTH: r_band_width <= pwdata[LW-1:0];
                ebcm_pkg::REG_GAP_VALUE:  r_gap_value  <= pwdata[ebcm_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            ebcm_pkg::REG_LENGTH_X:   prdata = DW'(r_length_x);
            ebcm_pkg::REG_LENGTH_Y:   prdata = DW'(r_length_y);
            ebcm_pkg::REG_BAND_WIDTH: prdata = DW'(r_band_width);
            ebcm_pkg::REG_GAP_VALUE:  prdata = DW'(r_gap_value);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.length_x   = r_length_x;
    assign o_cfg.length_y   = r_length_y;
    assign o_cfg.band_width = r_band_width;
    assign o_cfg.gap_value  = $signed(r_gap_value);

endmodule

// ----- hw/rtl/ebcm_sched.sv -----
// Row and column counters; position flags and row-memory read address per cell.
module ebcm_sched #(
    parameter int MAX_LENGTH = ebcm_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  ebcm_pkg::t_cfg                i_cfg,
    output ebcm_pkg::t_cell_flags         o_flags,
    output logic [$clog2(MAX_LENGTH)-1:0] o_rd_addr
);

    localparam int IDX_W  = $clog2(MAX_LENGTH + 1);
    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int LW     = ebcm_pkg::LEN_W;
    localparam int CMP_W  = ((IDX_W > LW) ? IDX_W : LW) + 1;

    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic [IDX_W-1:0] n_row;
    logic [IDX_W-1:0] n_col;
    logic [IDX_W-1:0] w_col_m1;

    logic [CMP_W-1:0] w_lx_raw, w_ly_raw, w_lx, w_ly, w_bw, w_i, w_j, w_max;

    // Clamp the lengths and widen everything for compares
    always_comb begin
        w_max    = CMP_W'(MAX_LENGTH);
        w_lx_raw = CMP_W'(i_cfg.length_x);
        w_ly_raw = CMP_W'(i_cfg.length_y);
        w_bw     = CMP_W'(i_cfg.band_width);
        w_i      = CMP_W'(r_row);
        w_j      = CMP_W'(r_col);
        priority if (w_lx_raw == '0)  w_lx = CMP_W'(1);
        else if (w_lx_raw > w_max)    w_lx = w_max;
        else                          w_lx = w_lx_raw;
        priority if (w_ly_raw == '0)  w_ly = CMP_W'(1);
        else if (w_ly_raw > w_max)    w_ly = w_max;
        else                          w_ly = w_ly_raw;
    end

    // Position flags of the cell at the counters
    always_comb begin
        o_flags.first_row = (w_i == CMP_W'(1));
        o_flags.first_col = (w_j == CMP_W'(1));
        o_flags.col_edge  = (w_i <= w_bw + CMP_W'(1));
        o_flags.diag_edge = (w_i <= w_bw + CMP_W'(2));
        o_flags.row_edge  = (w_j <= w_bw + CMP_W'(1));
        o_flags.in_band   = (w_j + w_bw >= w_i) && (w_j <= w_i + w_bw);
        o_flags.last      = (w_i >= w_lx) && (w_j >= w_ly);
    end

    assign w_col_m1  = r_col - IDX_W'(1);
    assign o_rd_addr = w_col_m1[ADDR_W-1:0];

    // Advance in row-major order, wrap after the last cell
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_j >= w_ly) begin
            n_col = IDX_W'(1);
            if (w_i >= w_lx) begin
                n_row = IDX_W'(1);
            end else begin
                n_row = r_row + IDX_W'(1);
            end
        end else begin
            n_col = r_col + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= IDX_W'(1);
            r_col <= IDX_W'(1);
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// ----- hw/rtl/ebcm_row_mem.sv -----
// Previous-row cost memory: one write port, one registered read port.
module ebcm_row_mem #(
    parameter int DEPTH  = ebcm_pkg::MAX_LENGTH_DEF,
    parameter int DATA_W = ebcm_pkg::COST_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Read returns the old entry on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/ebcm_cell.sv -----
// Cell stage: input register, add-and-min cost update, edge sums, result register.
module ebcm_cell #(
    parameter int MAX_LENGTH = ebcm_pkg::MAX_LENGTH_DEF,
    parameter int COST_WIDTH = ebcm_pkg::COST_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    output logic                                  o_accept,
    input  logic signed [ebcm_pkg::SAMPLE_W-1:0]  i_x_sample,
    input  logic signed [ebcm_pkg::SAMPLE_W-1:0]  i_y_sample,
    input  logic [ebcm_pkg::DIST_W-1:0]           i_pair_distance,
    input  ebcm_pkg::t_cell_flags                 i_flags,
    input  logic [$clog2(MAX_LENGTH)-1:0]         i_rd_addr,
    input  logic signed [ebcm_pkg::SAMPLE_W-1:0]  i_gap_value,
    input  logic [COST_WIDTH-1:0]                 i_rd_data,
    output logic                                  o_wr_en,
    output logic [$clog2(MAX_LENGTH)-1:0]         o_wr_addr,
    output logic [COST_WIDTH-1:0]                 o_wr_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ebcm_pkg::OUT_COST_W-1:0]       o_cell_cost,
    output logic                                  o_in_band,
    output logic                                  o_last_cell
);

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int SW     = ebcm_pkg::SAMPLE_W;
    localparam int OW     = ebcm_pkg::OUT_COST_W;
    localparam logic [COST_WIDTH-1:0] INF = {COST_WIDTH{1'b1}};

    // Sum that sticks at all ones on overflow; an infinite operand stays infinite
    function automatic logic [COST_WIDTH-1:0] sat_add(input logic [COST_WIDTH-1:0] a,
                                                      input logic [COST_WIDTH-1:0] b);
        logic [COST_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_WIDTH] ? INF : s[COST_WIDTH-1:0];
    endfunction

    // Absolute distance of a sample from the gap value
    function automatic logic [ebcm_pkg::DIST_W-1:0] gap_dist(input logic [SW-1:0] g,
                                                             input logic [SW-1:0] s);
        logic [SW:0] d;
        logic [SW:0] nd;
        d  = {g[SW-1], g} - {s[SW-1], s};
        nd = -d;
        return d[SW] ? nd[SW-1:0] : d[SW-1:0];
    endfunction

    // Input register
    logic                         r_s1_valid;
    logic [SW-1:0]                r_x;
    logic [SW-1:0]                r_y;
    logic [ebcm_pkg::DIST_W-1:0]  r_pd;
    ebcm_pkg::t_cell_flags        r_flags;
    logic [ADDR_W-1:0]            r_addr;
    logic                         r_fwd_hit;
    logic [COST_WIDTH-1:0]        r_fwd_data;

    // Running state
    logic [COST_WIDTH-1:0] r_left, r_diag, r_colsum, r_rowsum;

    // Result register
    logic                  r_out_valid;
    logic [OW-1:0]         r_out_cost;
    logic                  r_out_in_band;
    logic                  r_out_last;

    logic                  w_fire, w_accept;
    logic [COST_WIDTH-1:0] w_dx, w_dy, w_dp, w_colsum_inc, w_rowsum_inc;
    logic [COST_WIDTH-1:0] w_up, w_left, w_diag, w_a, w_b, w_c, w_min, w_cost;
    logic [OW+COST_WIDTH-1:0] w_cost_wide;

    assign w_fire     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && (!r_s1_valid || w_fire);
    assign o_in_ready = !r_s1_valid || w_fire;
    assign o_accept   = w_accept;

    // Neighbor selection and add-and-min
    always_comb begin
        w_dx = COST_WIDTH'(gap_dist(i_gap_value, r_x));
        w_dy = COST_WIDTH'(gap_dist(i_gap_value, r_y));
        w_dp = COST_WIDTH'(r_pd);
        w_colsum_inc = sat_add(r_colsum, w_dx);
        w_rowsum_inc = sat_add(r_rowsum, w_dy);

        if (r_flags.first_col) begin
            w_diag = r_flags.diag_edge ? r_colsum : INF;
            w_left = r_flags.col_edge ? w_colsum_inc : INF;
        end else begin
            w_diag = r_diag;
            w_left = r_left;
        end

        if (r_flags.first_row) begin
            w_up = r_flags.row_edge ? w_rowsum_inc : INF;
        end else begin
            w_up = r_fwd_hit ? r_fwd_data : i_rd_data;
        end

        w_a   = sat_add(w_up, w_dx);
        w_b   = sat_add(w_left, w_dy);
        w_c   = sat_add(w_diag, w_dp);
        w_min = (w_a < w_b) ? w_a : w_b;
        if (w_c < w_min) begin
            w_min = w_c;
        end
        w_cost      = r_flags.in_band ? w_min : INF;
        w_cost_wide = {{OW{1'b0}}, w_cost};
    end

    // Store the cell's cost for the next row
    assign o_wr_en   = w_fire;
    assign o_wr_addr = r_addr;
    assign o_wr_data = w_cost;

    // Control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_diag      <= '0;
            r_colsum    <= '0;
            r_rowsum    <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_fire) begin
                if (r_flags.last) begin
                    r_left   <= '0;
                    r_diag   <= '0;
                    r_colsum <= '0;
                    r_rowsum <= '0;
                end else begin
                    r_left <= w_cost;
                    r_diag <= w_up;
                    if (r_flags.first_col && r_flags.col_edge) begin
                        r_colsum <= w_colsum_inc;
                    end
                    if (r_flags.first_row && r_flags.row_edge) begin
                        r_rowsum <= w_rowsum_inc;
                    end
                end
            end
        end
    end

    // Payload: capture beat, forward a same-entry write that lands with the read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x        <= i_x_sample;
            r_y        <= i_y_sample;
            r_pd       <= i_pair_distance;
            r_flags    <= i_flags;
            r_addr     <= i_rd_addr;
            r_fwd_hit  <= w_fire && (r_addr == i_rd_addr);
            r_fwd_data <= w_cost;
        end
        if (w_fire) begin
            r_out_cost    <= w_cost_wide[OW-1:0];
            r_out_in_band <= r_flags.in_band;
            r_out_last    <= r_flags.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_cost = r_out_cost;
    assign o_in_band   = r_out_in_band;
    assign o_last_cell = r_out_last;

endmodule

// ----- hw/rtl/erp_banded_cost_matrix_core.sv -----
// Top level of the banded ERP cost matrix core.
// Usage:
//   Program length_x, length_y, band_width and gap_value over the APB port
//   (byte addresses 0x0, 0x4, 0x8, 0xC) while the core is idle.
//   Feed the interior cells in row-major order on the input channel, one beat
//   per cell: x sample of the row, y sample of the column, pair distance.
//   Each cell yields one result beat: cell cost (Q32.16, all ones = infinite),
//   an in-band flag and a last-cell flag; the last cell's cost is the distance.
//   After the last cell the core starts over at cell (1,1).
// Timing:
//   A cell's result passes the input register and then the result register;
//   it is valid once the cell stage fires. One cell is taken every cycle while
//   the output is not stalled; the limit is the left-neighbor loop, where a
//   cell's registered cost feeds the next cell's add-and-min, and
//   the single-read row memory supplies the upper neighbor for each cell.
// Reset and stalls:
//   Reset returns the counters to (1,1), clears edge sums, neighbor costs, valid flags.
//   The row memory is not cleared; each entry is written before it is read.
//   With the output stalled, one result and one taken cell are held, then
//   input ready drops until the receiver takes the pending result.
`include "assert_macros.svh"
module erp_banded_cost_matrix_core #(
    parameter int MAX_LENGTH = ebcm_pkg::MAX_LENGTH_DEF,
    parameter int COST_WIDTH = ebcm_pkg::COST_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ebcm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ebcm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ebcm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [ebcm_pkg::SAMPLE_W-1:0]  i_x_sample,
    input  logic signed [ebcm_pkg::SAMPLE_W-1:0]  i_y_sample,
    input  logic [ebcm_pkg::DIST_W-1:0]           i_pair_distance,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ebcm_pkg::OUT_COST_W-1:0]       o_cell_cost,
    output logic                                  o_in_band,
    output logic                                  o_last_cell
);

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int OW     = ebcm_pkg::OUT_COST_W;
    localparam logic [OW+COST_WIDTH-1:0] INF_WIDE = {{OW{1'b0}}, {COST_WIDTH{1'b1}}};
    localparam logic [OW-1:0] INF_OUT = INF_WIDE[OW-1:0];

    ebcm_pkg::t_cfg        w_cfg;
    ebcm_pkg::t_cell_flags w_flags;
    logic                  w_accept;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [COST_WIDTH-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [COST_WIDTH-1:0] w_wr_data;

    ebcm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ebcm_sched #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_cfg     (w_cfg),
        .o_flags   (w_flags),
        .o_rd_addr (w_rd_addr)
    );

    ebcm_row_mem #(
        .DEPTH  (MAX_LENGTH),
        .DATA_W (COST_WIDTH)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ebcm_cell #(
        .MAX_LENGTH (MAX_LENGTH),
        .COST_WIDTH (COST_WIDTH)
    ) u_cell (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .o_accept        (w_accept),
        .i_x_sample      (i_x_sample),
        .i_y_sample      (i_y_sample),
        .i_pair_distance (i_pair_distance),
        .i_flags         (w_flags),
        .i_rd_addr       (w_rd_addr),
        .i_gap_value     (w_cfg.gap_value),
        .i_rd_data       (w_rd_data),
        .o_wr_en         (w_wr_en),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_cost     (o_cell_cost),
        .o_in_band       (o_in_band),
        .o_last_cell     (o_last_cell)
    );

    // After the last cell is taken the counters sit at cell (1,1)
    `ASSERT_NEXT(a_wrap_after_last, w_accept && w_flags.last, w_flags.first_row && w_flags.first_col, "counters did not wrap after last cell")
    // An out-of-band result always reads as infinity
    `ASSERT_CLK(a_out_of_band_inf, !(o_out_valid && !o_in_band) || (o_cell_cost == INF_OUT), "out-of-band cell cost is not infinite")
    // Input stalls only when a result is pending and the receiver holds off
    `ASSERT_CLK(a_ready_only_on_stall, o_in_ready || (o_out_valid && !i_out_ready), "input stalled without output back-pressure")

endmodule

// ----- verif/erp_banded_cost_matrix_core_tb.sv -----
// Self-checking testbench for the banded ERP cost matrix core.
`timescale 1ns / 1ps

module erp_banded_cost_matrix_core_tb;

    localparam int          MAX_LEN      = ebcm_pkg::MAX_LENGTH_DEF;
    localparam int unsigned WHOLE_MATRIX = 32'h4000_0000;
    localparam int unsigned RANDOM_CELLS = 300;

    typedef logic [ebcm_pkg::OUT_COST_W-1:0] t_cost;

    typedef struct packed {
        t_cost cell_cost;
        logic  in_band;
        logic  last_cell;
    } t_cell_result;

    localparam t_cost COST_INF = '1;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [ebcm_pkg::APB_ADDR_W-1:0]        paddr;
    logic [ebcm_pkg::APB_DATA_W-1:0]        pwdata;
    logic [ebcm_pkg::APB_DATA_W-1:0]        prdata;
    logic                                   pready;
    logic                                   i_in_valid;
    logic                                   o_in_ready;
    logic signed [ebcm_pkg::SAMPLE_W-1:0]   i_x_sample;
    logic signed [ebcm_pkg::SAMPLE_W-1:0]   i_y_sample;
    logic [ebcm_pkg::DIST_W-1:0]            i_pair_distance;
    logic                                   o_out_valid;
    logic                                   i_out_ready;
    logic [ebcm_pkg::OUT_COST_W-1:0]        o_cell_cost;
    logic                                   o_in_band;
    logic                                   o_last_cell;

    // Sample tables for the current matrix: one x per row, one y per column
    logic [ebcm_pkg::SAMPLE_W-1:0] row_x [MAX_LEN];
    logic [ebcm_pkg::SAMPLE_W-1:0] col_y [MAX_LEN];

    // Banded ERP cost predictor plus the queue of cell results still owed
    class erp_cell_scoreboard;
        logic [ebcm_pkg::LEN_W-1:0]           len_x;
        logic [ebcm_pkg::LEN_W-1:0]           len_y;
        logic [ebcm_pkg::LEN_W-1:0]           band;
        logic signed [ebcm_pkg::SAMPLE_W-1:0] gap;
        t_cost                                row_mem [MAX_LEN];
        int unsigned                          row_idx;
        int unsigned                          col_idx;
        int unsigned                          hi_water;
        t_cost                                left_c;
        t_cost                                diag_c;
        t_cost                                col0_sum;
        t_cost                                row0_sum;
        t_cell_result                         pending_q [$];
        int                                   errors;

        function new();
            len_x    = 1;
            len_y    = 1;
            band     = 0;
            gap      = 0;
            hi_water = 0;
            errors   = 0;
            restart_matrix();
        endfunction

        function void restart_matrix();
            row_idx  = 1;
            col_idx  = 1;
            left_c   = '0;
            diag_c   = '0;
            col0_sum = '0;
            row0_sum = '0;
        endfunction

        function void write_reg(logic [ebcm_pkg::REG_IDX_W-1:0] idx,
                                logic [ebcm_pkg::APB_DATA_W-1:0] value);
            case (idx)
                ebcm_pkg::REG_LENGTH_X:   len_x = value[ebcm_pkg::LEN_W-1:0];
                ebcm_pkg::REG_LENGTH_Y:   len_y = value[ebcm_pkg::LEN_W-1:0];
                ebcm_pkg::REG_BAND_WIDTH: band  = value[ebcm_pkg::LEN_W-1:0];
                ebcm_pkg::REG_GAP_VALUE:  gap   = value[ebcm_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero counts as one, anything past the row memory as its depth
        function int unsigned clamp_len(logic [ebcm_pkg::LEN_W-1:0] n);
            if (n == 0) return 1;
            if (n > MAX_LEN) return MAX_LEN;
            return n;
        endfunction

        function t_cost gap_cost(logic signed [ebcm_pkg::SAMPLE_W-1:0] s);
            longint diff;
            diff = longint'(gap) - longint'(s);
            if (diff < 0) diff = -diff;
            return t_cost'(diff);
        endfunction

        // Saturate at infinity; an infinite operand stays infinite
        function t_cost sat_add(t_cost a, t_cost b);
            logic [ebcm_pkg::OUT_COST_W:0] s;
            if (a == COST_INF || b == COST_INF) return COST_INF;
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, COST_INF}) return COST_INF;
            return s[ebcm_pkg::OUT_COST_W-1:0];
        endfunction

        function void report_field(string field, t_cost want, t_cost got);
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        endfunction

        // Work out the result of one accepted cell and queue it
        function bit note_cell(logic signed [ebcm_pkg::SAMPLE_W-1:0] x,
                               logic signed [ebcm_pkg::SAMPLE_W-1:0] y,
                               logic [ebcm_pkg::DIST_W-1:0] d);
            int unsigned  lx, ly, bw, i, j;
            t_cost        dx, dy, up, lft, dg, a, b, c, cost;
            t_cell_result r;
            lx = clamp_len(len_x);
            ly = clamp_len(len_y);
            bw = band;
            i  = row_idx;
            j  = col_idx;
            dx = gap_cost(x);
            dy = gap_cost(y);

            // Column one takes its left and diagonal neighbors from the column-zero sums
            if (j == 1) begin
                dg = (i - 1 <= bw + 1) ? col0_sum : COST_INF;
                if (i <= bw + 1) begin
                    col0_sum = sat_add(col0_sum, dx);
                    lft      = col0_sum;
                end else begin
                    lft = COST_INF;
                end
            end else begin
                dg  = diag_c;
                lft = left_c;
            end

            // Row one takes its upper neighbor from the row-zero sum
            if (i == 1) begin
                if (j <= bw + 1) begin
                    row0_sum = sat_add(row0_sum, dy);
                    up       = row0_sum;
                end else begin
                    up = COST_INF;
                end
            end else begin
                up = row_mem[j-1];
            end

            r.in_band = (j + bw >= i) && (j <= i + bw);
            if (r.in_band) begin
                a    = sat_add(up, dx);
                b    = sat_add(lft, dy);
                c    = sat_add(dg, t_cost'(d));
                cost = (a < b) ? a : b;
                if (c < cost) cost = c;
            end else begin
                cost = COST_INF;
            end

            row_mem[j-1] = cost;
            left_c       = cost;
            diag_c       = up;
            if (j > hi_water) hi_water = j;

            // Advance in row-major order, wrap to (1,1) after the last cell
            r.last_cell = (i >= lx) && (j >= ly);
            if (j >= ly) begin
                if (i >= lx) begin
                    restart_matrix();
                end else begin
                    row_idx = i + 1;
                    col_idx = 1;
                end
            end else begin
                col_idx = j + 1;
            end

            r.cell_cost = cost;
            pending_q.push_back(r);
            return r.last_cell;
        endfunction

        function void check_result(t_cell_result got);
            t_cell_result want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with no cell pending, got cost %h",
                         $time, got.cell_cost);
                return;
            end
            want = pending_q.pop_front();
            if (got.cell_cost !== want.cell_cost)
                report_field("cell_cost", want.cell_cost, got.cell_cost);
            if (got.in_band !== want.in_band)
                report_field("in_band", t_cost'(want.in_band), t_cost'(got.in_band));
            if (got.last_cell !== want.last_cell)
                report_field("last_cell", t_cost'(want.last_cell), t_cost'(got.last_cell));
        endfunction
    endclass

    erp_cell_scoreboard cost_board = new();

    erp_banded_cost_matrix_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_x_sample      (i_x_sample),
        .i_y_sample      (i_y_sample),
        .i_pair_distance (i_pair_distance),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_cost     (o_cell_cost),
        .o_in_band       (o_in_band),
        .o_last_cell     (o_last_cell)
    );

    // 125 MHz clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check every result beat against the oldest pending cell
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            cost_board.check_result(t_cell_result'({o_cell_cost, o_in_band, o_last_cell}));
    end

    // Stall the result side: mostly short, a few long stalls, some long open stretches
    initial begin
        int unsigned r;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(99);
            if (r < 55) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(6, 1)) @(posedge i_clk);
            end else if (r < 85) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(3, 1)) @(posedge i_clk);
            end else if (r < 93) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(40, 8)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(150, 30)) @(posedge i_clk);
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #15ms;
        $display("erp_banded_cost_matrix_core verification failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Extremes, full-range words, or small values around zero
    function automatic logic [ebcm_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        if (r < 5) return $urandom();
        return $urandom_range(32'h0010_0000) - 32'h0008_0000;
    endfunction

    function automatic logic [ebcm_pkg::APB_DATA_W-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 88) return $urandom_range(10, 1);
        return $urandom_range(24, 11);
    endfunction

    task automatic fill_samples();
        for (int k = 0; k < MAX_LEN; k++) begin
            row_x[k] = pick_sample();
            col_y[k] = pick_sample();
        end
    endtask

    // One APB transfer; the caller drops psel afterwards
    task automatic apb_access(logic wr, logic [ebcm_pkg::REG_IDX_W-1:0] idx,
                              logic [ebcm_pkg::APB_DATA_W-1:0] wdata,
                              output logic [ebcm_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
    endtask

    // Write a register, mirror it in the predictor, read it back
    task automatic write_reg(logic [ebcm_pkg::REG_IDX_W-1:0] idx,
                             logic [ebcm_pkg::APB_DATA_W-1:0] value);
        logic [ebcm_pkg::APB_DATA_W-1:0] rd;
        logic [ebcm_pkg::APB_DATA_W-1:0] want;
        apb_access(1'b1, idx, value, rd);
        cost_board.write_reg(idx, value);
        apb_access(1'b0, idx, '0, rd);
        want = value;
        if (idx != ebcm_pkg::REG_GAP_VALUE) begin
            want                         = '0;
            want[ebcm_pkg::LEN_W-1:0]    = value[ebcm_pkg::LEN_W-1:0];
        end
        if (rd !== want) cost_board.report_field("register readback", t_cost'(want), t_cost'(rd));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold valid with the payload until the beat is taken
    task automatic send_cell(logic signed [ebcm_pkg::SAMPLE_W-1:0] x,
                             logic signed [ebcm_pkg::SAMPLE_W-1:0] y,
                             logic [ebcm_pkg::DIST_W-1:0] d, output bit last_cell);
        i_in_valid      <= 1'b1;
        i_x_sample      <= x;
        i_y_sample      <= y;
        i_pair_distance <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        last_cell = cost_board.note_cell(x, y, d);
    endtask

    task automatic pause_input(int unsigned n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cost_board.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Feed cells from the sample tables until the limit or the end of the matrix
    task automatic run_cells(int unsigned limit, bit tight, output int unsigned sent);
        int unsigned                          i, j;
        logic signed [ebcm_pkg::SAMPLE_W-1:0] x, y;
        logic [ebcm_pkg::DIST_W-1:0]          d;
        longint                               diff;
        bit                                   last_cell;
        sent      = 0;
        last_cell = 0;
        while (sent < limit && !last_cell) begin
            i    = cost_board.row_idx;
            j    = cost_board.col_idx;
            x    = ($urandom_range(9) == 0) ? pick_sample() : row_x[i-1];
            y    = ($urandom_range(9) == 0) ? pick_sample() : col_y[j-1];
            diff = longint'(x) - longint'(y);
            d    = (diff < 0) ? ebcm_pkg::DIST_W'(-diff) : ebcm_pkg::DIST_W'(diff);
            if ($urandom_range(4) == 0) d = $urandom();
            send_cell(x, y, d, last_cell);
            sent++;
            if (!tight && sent < limit && !last_cell) pause_input(pick_gap());
        end
    endtask

    // Pick a fresh setting; mid-matrix, keep new columns within rows already stored
    task automatic random_config();
        logic [ebcm_pkg::APB_DATA_W-1:0] lx, ly, bw, g;
        int unsigned                     r;
        lx = pick_len();
        ly = pick_len();
        if (cost_board.row_idx > 1 &&
            cost_board.clamp_len(ly[ebcm_pkg::LEN_W-1:0]) > cost_board.hi_water)
            ly = cost_board.hi_water;
        r = $urandom_range(99);
        if (r < 40) bw = $urandom_range(3);
        else if (r < 70) bw = $urandom_range(16);
        else if (r < 85) bw = 0;
        else bw = $urandom_range(2047, 17);
        r = $urandom_range(99);
        if (r < 20) g = 0;
        else if (r < 70) g = $urandom_range(32'h0010_0000) - 32'h0008_0000;
        else g = pick_sample();
        if ($urandom_range(3) != 0) write_reg(ebcm_pkg::REG_LENGTH_X, lx);
        if ($urandom_range(3) != 0) write_reg(ebcm_pkg::REG_LENGTH_Y, ly);
        if ($urandom_range(3) != 0) write_reg(ebcm_pkg::REG_BAND_WIDTH, bw);
        if ($urandom_range(3) != 0) write_reg(ebcm_pkg::REG_GAP_VALUE, g);
    endtask

    initial begin
        int unsigned sent;
        int unsigned random_cells;
        int unsigned limit;
        bit          tight;
        bit          last_cell;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_x_sample      <= '0;
        i_y_sample      <= '0;
        i_pair_distance <= '0;
        i_rst_n         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fill_samples();

        // Reset setting: every cell is a 1x1 matrix; extreme samples and distances
        send_cell(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, last_cell);
        send_cell(32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0000_0000, last_cell);
        send_cell(32'sh0000_0000, 32'sh0000_0000, 32'h0001_0000, last_cell);
        settle();

        // 3x3 with a zero band: off-diagonal cells fall outside, gap at its minimum
        write_reg(ebcm_pkg::REG_LENGTH_X, 3);
        write_reg(ebcm_pkg::REG_LENGTH_Y, 3);
        write_reg(ebcm_pkg::REG_BAND_WIDTH, 0);
        write_reg(ebcm_pkg::REG_GAP_VALUE, 32'h8000_0000);
        row_x[0] = 32'h7FFF_FFFF;
        row_x[1] = 32'h8000_0000;
        row_x[2] = 32'h0000_0000;
        col_y[0] = 32'h8000_0000;
        col_y[1] = 32'h7FFF_FFFF;
        col_y[2] = 32'h0001_8000;
        run_cells(9, 1'b1, sent);
        settle();

        // Zero lengths act as one; gap at its maximum
        write_reg(ebcm_pkg::REG_GAP_VALUE, 32'h7FFF_FFFF);
        write_reg(ebcm_pkg::REG_LENGTH_X, 0);
        write_reg(ebcm_pkg::REG_LENGTH_Y, 0);
        write_reg(ebcm_pkg::REG_BAND_WIDTH, 1024);
        run_cells(2, 1'b0, sent);
        settle();

        // Shrink both lengths mid-matrix: the next cell closes the matrix
        fill_samples();
        write_reg(ebcm_pkg::REG_LENGTH_X, 4);
        write_reg(ebcm_pkg::REG_LENGTH_Y, 4);
        write_reg(ebcm_pkg::REG_BAND_WIDTH, 2047);
        write_reg(ebcm_pkg::REG_GAP_VALUE, 0);
        run_cells(6, 1'b0, sent);
        settle();
        write_reg(ebcm_pkg::REG_LENGTH_X, 2);
        write_reg(ebcm_pkg::REG_LENGTH_Y, 2);
        run_cells(WHOLE_MATRIX, 1'b0, sent);
        settle();

        // Oversized length clamps to the row memory depth: one full row
        fill_samples();
        write_reg(ebcm_pkg::REG_LENGTH_X, 1);
        write_reg(ebcm_pkg::REG_LENGTH_Y, 2047);
        write_reg(ebcm_pkg::REG_BAND_WIDTH, 2047);
        write_reg(ebcm_pkg::REG_GAP_VALUE, pick_sample());
        run_cells(WHOLE_MATRIX, 1'b0, sent);
        settle();

        // Random settings: mostly whole matrices, some cut short and reconfigured
        random_cells = 0;
        while (random_cells < RANDOM_CELLS) begin
            tight = ($urandom_range(3) == 0);
            fill_samples();
            random_config();
            if ($urandom_range(4) == 0) limit = $urandom_range(20, 1);
            else limit = WHOLE_MATRIX;
            run_cells(limit, tight, sent);
            random_cells += sent;
            settle();
        end

        // Catch any stray result beats
        repeat (10) @(posedge i_clk);
        if (cost_board.errors == 0) begin
            $display("erp_banded_cost_matrix_core verification clean");
        end else begin
            $display("erp_banded_cost_matrix_core verification failed");
        end
        $finish;
    end

endmodule
